>>> rtl/type3_compensator_biquad_pi_defines.svh
// assertion macros for the type iii compensator block
// no dependencies; included by files that carry concurrent assertions
`ifndef TYPE3_COMPENSATOR_BIQUAD_PI_DEFINES_SVH
`define TYPE3_COMPENSATOR_BIQUAD_PI_DEFINES_SVH

// same-cycle implication, disabled during reset
`define T3C_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define T3C_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/t3c_pkg.sv
// types, constants and saturation helper for the type iii compensator
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package t3c_pkg;

	// field widths
	localparam int SAMPLE_W = 24;
	localparam int DRIVE_W = 32;
	localparam int COEF_W = 32;
	localparam int SIG_W = 48;
	localparam int CFG_IDX_W = 8;
	localparam int HALF_W = 24;

	// only the low bits of the q shift are used
	localparam int QMASK = 'h0F;

	// product and accumulator widths: 33 x 25 product, five terms
	localparam int PROD_W = 58;
	localparam int ACC_W = 61;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_AW = 8'd7;

	// 48-bit saturation bounds, sign-extended to 64
	localparam logic signed [63:0] S48_MAX_64 = 64'sd140737488355327;
	localparam logic signed [63:0] S48_MIN_64 = -64'sd140737488355328;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MAC,
		ST_DRAIN,
		ST_FIN,
		ST_INT,
		ST_PI,
		ST_LIM,
		ST_SCALE,
		ST_DONE
	} state_t;

	// which sum of products the shared multiplier is working on
	typedef enum logic [1:0] {
		PH_FILT,
		PH_PROP,
		PH_INTG,
		PH_KA
	} phase_t;

	// saturate a 64-bit signed value to 48 bits
	function automatic logic signed [SIG_W-1:0] sat48(input logic signed [63:0] v);
		logic signed [SIG_W-1:0] r;
		if (v > S48_MAX_64) begin
			r = S48_MAX_64[SIG_W-1:0];
		end else if (v < S48_MIN_64) begin
			r = S48_MIN_64[SIG_W-1:0];
		end else begin
			r = v[SIG_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/t3c_if.sv
// valid/ready channel interfaces: sample word in, drive word out, register write
// depends on t3c_pkg for field widths
`default_nettype none

interface t3c_sample_if;
	import t3c_pkg::*;
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] reference_value;
	logic signed [SAMPLE_W-1:0] feedback_value;
	modport source(output valid, reference_value, feedback_value, input ready);
	modport sink(input valid, reference_value, feedback_value, output ready);
endinterface

interface t3c_drive_if;
	import t3c_pkg::*;
	logic valid;
	logic ready;
	logic signed [DRIVE_W-1:0] drive_output;
	modport source(output valid, drive_output, input ready);
	modport sink(input valid, drive_output, output ready);
endinterface

interface t3c_cfg_if;
	import t3c_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [COEF_W-1:0] wdata;
	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/type3_compensator_biquad_pi.sv
// one word is worked on at a time: the sequencer makes 18 passes through the single
// 33x25 multiplier plus finalize, integrator, pi-sum and limit steps before the drive
// word is ready for the output register.
// the sample side is not ready while a word is being worked on; a finished drive
// word waits in the output register. arst_n clears coefficients, filter and pi
// history and the sequencer; register writes are taken at any time.
// depends on t3c_pkg, t3c_if.sv and type3_compensator_biquad_pi_defines.svh
`default_nettype none
`include "type3_compensator_biquad_pi_defines.svh"

module type3_compensator_biquad_pi #(
	parameter int Q_SHIFT = 12,
	parameter logic signed [31:0] KA_GAIN = 32'sd268435456,
	parameter logic signed [47:0] PI_LIMIT_HIGH = 48'sd16777216,
	parameter logic signed [47:0] PI_LIMIT_LOW = -48'sd16777216,
	parameter logic signed [31:0] OUT_LIMIT_HIGH = 32'sd32767,
	parameter logic signed [31:0] OUT_LIMIT_LOW = -32'sd32768
) (
	input wire logic clk,
	input wire logic arst_n,
	t3c_sample_if.sink sample_in,
	t3c_drive_if.source drive_out,
	t3c_cfg_if.sink cfg
);
	import t3c_pkg::*;

	localparam int Q_EFF = Q_SHIFT & QMASK;
	localparam int SHIFT = 24 - Q_EFF;
	localparam logic [48:0] RND_MASK = 49'((64'd1 << SHIFT) - 64'd1);

	// configuration registers
	logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q, kp_q, ki_q, kc_q;

	// sequencer
	state_t state_q, state_d;
	phase_t phase_q;
	logic [2:0] term_q;
	logic half_q;
	logic [2:0] last_term;
	logic last_issue;

	// item and history
	logic signed [SAMPLE_W-1:0] ref_q, fdb_q;
	logic signed [SIG_W-1:0] u_q, in_d1_q, in_d2_q, out_d1_q, out_d2_q;
	logic signed [SIG_W-1:0] y_q, p_q, integ_q, serr_q, pi_q, lim_q, m_q;

	// shared multiplier and accumulators
	logic signed [COEF_W:0] coef_sel;
	logic signed [SIG_W-1:0] samp_sel;
	logic signed [HALF_W:0] op_sel;
	logic signed [PROD_W-1:0] prod_s1;
	logic prod_v_s1, prod_hi_s1;
	logic signed [ACC_W-1:0] hi_acc_q, lo_acc_q;

	// finalize and post-processing
	logic signed [ACC_W:0] mac_tot;
	logic signed [SIG_W-1:0] mac48;
	logic signed [SIG_W-1:0] lim_c;
	logic signed [48:0] scale_ext, scale_shr;
	logic signed [DRIVE_W-1:0] res_c;
	logic signed [DRIVE_W-1:0] res_q;

	// output register
	logic out_v_q;
	logic signed [DRIVE_W-1:0] drive_q;

	// register writes, unknown indexes ignored
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0; b1_q <= '0; b2_q <= '0; a1_q <= '0;
			a2_q <= '0; kp_q <= '0; ki_q <= '0; kc_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_COEF_B0: b0_q <= cfg.wdata;
				REG_COEF_B1: b1_q <= cfg.wdata;
				REG_COEF_B2: b2_q <= cfg.wdata;
				REG_COEF_A1: a1_q <= cfg.wdata;
				REG_COEF_A2: a2_q <= cfg.wdata;
				REG_GAIN_PROP: kp_q <= cfg.wdata;
				REG_GAIN_INTEG: ki_q <= cfg.wdata;
				REG_GAIN_AW: kc_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		coef_sel = '0;
		samp_sel = '0;
		last_term = 3'd0;
		case (phase_q)
			PH_FILT: begin
				last_term = 3'd4;
				case (term_q)
					3'd0: begin coef_sel = 33'(b0_q); samp_sel = u_q; end
					3'd1: begin coef_sel = 33'(b1_q); samp_sel = in_d1_q; end
					3'd2: begin coef_sel = 33'(b2_q); samp_sel = in_d2_q; end
					3'd3: begin coef_sel = -33'(a1_q); samp_sel = out_d1_q; end
					3'd4: begin coef_sel = -33'(a2_q); samp_sel = out_d2_q; end
					default: ;
				endcase
			end
			PH_PROP: begin
				coef_sel = 33'(kp_q);
				samp_sel = y_q;
			end
			PH_INTG: begin
				last_term = 3'd1;
				if (term_q == 3'd0) begin
					coef_sel = 33'(ki_q);
					samp_sel = y_q;
				end else begin
					coef_sel = 33'(kc_q);
					samp_sel = serr_q;
				end
			end
			PH_KA: begin
				coef_sel = 33'(KA_GAIN);
				samp_sel = lim_q;
			end
			default: ;
		endcase
		// upper half signed, lower half unsigned
		if (!half_q) begin
			op_sel = {samp_sel[SIG_W-1], samp_sel[SIG_W-1:HALF_W]};
		end else begin
			op_sel = {1'b0, samp_sel[HALF_W-1:0]};
		end
	end

	assign last_issue = half_q && (term_q == last_term);

	// exact sum of products, floor shift by 28, saturate
	assign mac_tot = 62'(hi_acc_q) + 62'(lo_acc_q >>> HALF_W);
	assign mac48 = sat48(64'(mac_tot >>> 4));

	// pi limit, high limit tested first
	always_comb begin
		if (pi_q > PI_LIMIT_HIGH) begin
			lim_c = PI_LIMIT_HIGH;
		end else if (pi_q < PI_LIMIT_LOW) begin
			lim_c = PI_LIMIT_LOW;
		end else begin
			lim_c = pi_q;
		end
	end

	// final scaling toward zero and output clamp
	always_comb begin
		scale_ext = 49'(m_q);
		if (m_q[SIG_W-1]) begin
			scale_ext = scale_ext + $signed(RND_MASK);
		end
		scale_shr = scale_ext >>> SHIFT;
		if (scale_shr > 49'(OUT_LIMIT_HIGH)) begin
			res_c = OUT_LIMIT_HIGH;
		end else if (scale_shr < 49'(OUT_LIMIT_LOW)) begin
			res_c = OUT_LIMIT_LOW;
		end else begin
			res_c = scale_shr[DRIVE_W-1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sample-side ready
	always_comb begin
		state_d = state_q;
		sample_in.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_in.ready = 1'b1;
				if (sample_in.valid) state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_MAC;
			ST_MAC: if (last_issue) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN: begin
				case (phase_q)
					PH_INTG: state_d = ST_INT;
					PH_KA: state_d = ST_SCALE;
					default: state_d = ST_MAC;
				endcase
			end
			ST_INT: state_d = ST_PI;
			ST_PI: state_d = ST_LIM;
			ST_LIM: state_d = ST_MAC;
			ST_SCALE: state_d = ST_DONE;
			ST_DONE: if (!out_v_q || drive_out.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer counters, multiplier stage and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FILT;
			term_q <= '0;
			half_q <= 1'b0;
			prod_v_s1 <= 1'b0;
			prod_hi_s1 <= 1'b0;
			prod_s1 <= '0;
			hi_acc_q <= '0;
			lo_acc_q <= '0;
		end else begin
			prod_v_s1 <= (state_q == ST_MAC);
			if (prod_v_s1) begin
				if (prod_hi_s1) begin
					hi_acc_q <= hi_acc_q + 61'(prod_s1);
				end else begin
					lo_acc_q <= lo_acc_q + 61'(prod_s1);
				end
			end
			case (state_q)
				ST_DIFF: begin
					phase_q <= PH_FILT;
					term_q <= '0;
					half_q <= 1'b0;
				end
				ST_MAC: begin
					prod_s1 <= coef_sel * op_sel;
					prod_hi_s1 <= !half_q;
					half_q <= !half_q;
					if (half_q) term_q <= term_q + 3'd1;
				end
				ST_FIN: begin
					hi_acc_q <= '0;
					lo_acc_q <= '0;
					term_q <= '0;
					half_q <= 1'b0;
					case (phase_q)
						PH_FILT: phase_q <= PH_PROP;
						PH_PROP: phase_q <= PH_INTG;
						default: ;
					endcase
				end
				ST_LIM: phase_q <= PH_KA;
				default: ;
			endcase
		end
	end

	// filter and pi history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_d1_q <= '0;
			in_d2_q <= '0;
			out_d1_q <= '0;
			out_d2_q <= '0;
			integ_q <= '0;
			serr_q <= '0;
		end else begin
			case (state_q)
				ST_FIN: begin
					if (phase_q == PH_FILT) begin
						in_d2_q <= in_d1_q;
						in_d1_q <= u_q;
						out_d2_q <= out_d1_q;
						out_d1_q <= mac48;
					end
				end
				ST_INT: integ_q <= sat48(64'(integ_q) + 64'(m_q));
				ST_LIM: serr_q <= sat48(64'(lim_c) - 64'(pi_q));
				default: ;
			endcase
		end
	end

	// per-item working values
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ref_q <= sample_in.reference_value;
				fdb_q <= sample_in.feedback_value;
			end
			ST_DIFF: u_q <= sat48((64'(ref_q) - 64'(fdb_q)) <<< SHIFT);
			ST_FIN: begin
				case (phase_q)
					PH_FILT: y_q <= mac48;
					PH_PROP: p_q <= mac48;
					default: m_q <= mac48;
				endcase
			end
			ST_PI: pi_q <= sat48(64'(p_q) + 64'(integ_q));
			ST_LIM: lim_q <= lim_c;
			ST_SCALE: res_q <= res_c;
			default: ;
		endcase
	end

	// output register, refilled in the cycle its word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_v_q || drive_out.ready)) begin
			out_v_q <= 1'b1;
		end else if (drive_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_v_q || drive_out.ready)) begin
			drive_q <= res_q;
		end
	end

	assign drive_out.valid = out_v_q;
	assign drive_out.drive_output = drive_q;

	// checks
	`T3C_ASSERT_NEXT(a_accept_starts, clk, arst_n, sample_in.valid && sample_in.ready,
		state_q == ST_DIFF, "accepted word did not start the sequence")
	`T3C_ASSERT_SAME(a_prod_in_mac, clk, arst_n, prod_v_s1,
		state_q == ST_MAC || state_q == ST_DRAIN, "product pending outside mac steps")
	`T3C_ASSERT_SAME(a_out_from_done, clk, arst_n, $rose(drive_out.valid),
		$past(state_q == ST_DONE), "drive word appeared without a finished item")
	`T3C_ASSERT_NEXT(a_integ_idle, clk, arst_n, state_q == ST_IDLE,
		$stable(integ_q) && $stable(serr_q), "pi history changed while idle")

endmodule

`default_nettype wire
